// ===== sv/lbc2d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the zero-padded 2D convolution line buffer.
// Used by the controller, the datapath and the top level.
package lbc2d_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int FRAC_BITS        = 8;
  localparam int WIN_DIM_DEF      = 3;
  localparam int LINE_DEPTH_DEF   = 1024;
  localparam int SIDE_W           = 10;
  localparam int OPCODE_W         = 2;
  localparam int COEF_IDX_W       = 6;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(64);

  localparam logic [OPCODE_W-1:0] OP_PIXEL  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DRAIN  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COEF   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // register index is paddr[2]
  localparam logic REG_IMAGE_SIDE = 1'b0;

  typedef struct packed {
    logic [OPCODE_W-1:0]          opcode;
    logic signed [SAMPLE_WIDTH-1:0] pixel_value;
    logic [COEF_IDX_W-1:0]        coef_index;
    logic signed [SAMPLE_WIDTH-1:0] coef_value;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] conv_value;
    logic                           frame_last;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic line_re;
    logic line_we;
    logic shift;
    logic sample_zero;
    logic ker_we;
    logic ker_zero;
    logic mac_step;
    logic mac_first;
    logic out_load;
    logic out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/line_buffer_conv2d_same_padding.sv =====
`timescale 1ns / 1ps
// Same-size 2D convolution with zero padding over a square raster image.
// Input channel (in_valid/in_stall/in_word): pixels, drain ticks and kernel
// coefficient loads. Output channel (out_valid/out_stall/out_word): one word
// per output pixel, frame_last set on the last one of a frame. Config port:
// APB-style, image_side at byte address 0.
// Each grid position visited is a line RAM read, then a window shift and
// write-back; a position that yields a result then runs through the single
// shared multiplier before the output register is loaded. A pixel first
// walks the padding positions ahead of it: 2*PAD at a row start, PAD*(V+1)
// at a frame start (V = side + 2*PAD). Kernel loads and ignored items are
// taken in the idle state, without a grid visit.
// After reset the block runs a clearing pass over the line RAM and kernel
// RAM, holding in_stall high; config writes are taken meanwhile. If the
// receiver stalls, the finished word waits in the output register; the next
// item is still accepted, and the block waits, holding in_stall, once a
// further result is ready and the register is still full.
// Depends on lbc2d_pkg, lbc2d_ctrl, lbc2d_dp and lbc2d_ram.
module line_buffer_conv2d_same_padding #(
  parameter int WIN_DIM    = lbc2d_pkg::WIN_DIM_DEF,
  parameter int LINE_DEPTH = lbc2d_pkg::LINE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lbc2d_pkg::in_word_t                 in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lbc2d_pkg::out_word_t                out_word,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lbc2d_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [lbc2d_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lbc2d_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import lbc2d_pkg::*;

  localparam int TAPS = WIN_DIM * WIN_DIM;

  logic [SIDE_W-1:0]              side_r;
  dp_cmd_t                        cmd;
  dp_status_t                     status;
  logic [$clog2(LINE_DEPTH)-1:0]  line_addr;
  logic [$clog2(TAPS)-1:0]        ker_addr;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IMAGE_SIDE) ? CFG_DATA_W'(side_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_IMAGE_SIDE) begin
      side_r <= pwdata[SIDE_W-1:0];
    end
  end

  lbc2d_ctrl #(.WIN_DIM(WIN_DIM), .LINE_DEPTH(LINE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .image_side (side_r),
    .status     (status),
    .cmd        (cmd),
    .line_addr  (line_addr),
    .ker_addr   (ker_addr)
  );

  lbc2d_dp #(.WIN_DIM(WIN_DIM), .LINE_DEPTH(LINE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .line_addr (line_addr),
    .ker_addr  (ker_addr),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== sv/lbc2d_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module lbc2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/lbc2d_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: clearing pass, grid walk, visit sequencing and MAC counting.
// Depends on lbc2d_pkg.
module lbc2d_ctrl #(
  parameter int WIN_DIM    = 3,
  parameter int LINE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lbc2d_pkg::in_word_t                  in_word,
  input  logic [lbc2d_pkg::SIDE_W-1:0]         image_side,
  input  lbc2d_pkg::dp_status_t                status,
  output lbc2d_pkg::dp_cmd_t                   cmd,
  output logic [$clog2(LINE_DEPTH)-1:0]        line_addr,
  output logic [$clog2(WIN_DIM*WIN_DIM)-1:0]   ker_addr
);
  import lbc2d_pkg::*;

  localparam int PAD    = (WIN_DIM - 1) / 2;
  localparam int TAPS   = WIN_DIM * WIN_DIM;
  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam int TAP_W  = $clog2(TAPS);
  localparam int TC_W   = $clog2(TAPS + 2);
  localparam int POS_W  = $clog2(LINE_DEPTH + 1);
  localparam int CW     = ((POS_W > SIDE_W) ? POS_W : SIDE_W) + 1;
  localparam int CLR_N  = (LINE_DEPTH > TAPS) ? LINE_DEPTH : TAPS;
  localparam int CLR_W  = $clog2(CLR_N);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_SHIFT = 6'b001000,
    ST_MAC   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic             pix_op_r, pix_op_nxt;
  logic             done_r, done_nxt;
  logic             last_r, last_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [TC_W-1:0]  tap_cnt_r, tap_cnt_nxt;

  logic [CW-1:0] s_eff, v_len, last_pos, row_x, col_x, r0, c0;
  logic          accept, int0, int_cur, beyond;

  function automatic logic interior(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                    input logic [CW-1:0] s);
    logic [CW-1:0] hi;
    hi = s + CW'(PAD);
    return (r >= CW'(PAD)) && (r < hi) && (c >= CW'(PAD)) && (c < hi);
  endfunction

  always_comb begin
    if (image_side == '0) begin
      s_eff = CW'(1);
    end else if (CW'(image_side) > CW'(LINE_DEPTH - 2 * PAD)) begin
      s_eff = CW'(LINE_DEPTH - 2 * PAD);
    end else begin
      s_eff = CW'(image_side);
    end
    v_len    = s_eff + CW'(2 * PAD);
    last_pos = s_eff + CW'(PAD) - CW'(1);
    row_x    = CW'(row_r);
    col_x    = CW'(col_r);
    if (row_x >= v_len || col_x >= v_len) begin
      r0 = '0;
      c0 = '0;
    end else begin
      r0 = row_x;
      c0 = col_x;
    end
    int0    = interior(r0, c0, s_eff);
    int_cur = interior(row_x, col_x, s_eff);
    beyond  = (r0 > last_pos) || (r0 == last_pos && c0 > last_pos);
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    pix_op_nxt  = pix_op_r;
    done_nxt    = done_r;
    last_nxt    = last_r;
    clr_cnt_nxt = clr_cnt_r;
    tap_cnt_nxt = tap_cnt_r;
    cmd         = '0;
    line_addr   = col_r[ADDR_W-1:0];
    ker_addr    = in_word.coef_index[TAP_W-1:0];
    case (state_r)
      ST_CLEAR: begin
        cmd.clear    = 1'b1;
        cmd.ker_zero = 1'b1;
        line_addr    = clr_cnt_r[ADDR_W-1:0];
        ker_addr     = clr_cnt_r[TAP_W-1:0];
        cmd.line_we  = (32'(clr_cnt_r) < LINE_DEPTH);
        cmd.ker_we   = (32'(clr_cnt_r) < TAPS);
        clr_cnt_nxt  = clr_cnt_r + CLR_W'(1);
        if (clr_cnt_r == CLR_W'(CLR_N - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_word.opcode)
            OP_PIXEL: begin
              row_nxt     = r0[POS_W-1:0];
              col_nxt     = c0[POS_W-1:0];
              cmd.capture = 1'b1;
              pix_op_nxt  = 1'b1;
              if (!beyond) begin
                state_nxt = ST_READ;
              end
            end
            OP_DRAIN: begin
              row_nxt    = r0[POS_W-1:0];
              col_nxt    = c0[POS_W-1:0];
              pix_op_nxt = 1'b0;
              if (!int0) begin
                state_nxt = ST_READ;
              end
            end
            OP_COEF: begin
              cmd.ker_we = (32'(in_word.coef_index) < TAPS);
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.line_re = 1'b1;
        state_nxt   = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift       = 1'b1;
        cmd.line_we     = 1'b1;
        cmd.sample_zero = !(pix_op_r && int_cur);
        done_nxt        = !pix_op_r || int_cur;
        last_nxt        = (row_x == v_len - CW'(1)) && (col_x == v_len - CW'(1));
        if (col_x + CW'(1) >= v_len) begin
          col_nxt = '0;
          if (row_x + CW'(1) >= v_len) begin
            row_nxt = '0;
          end else begin
            row_nxt = row_r + POS_W'(1);
          end
        end else begin
          col_nxt = col_r + POS_W'(1);
        end
        if (row_x >= CW'(WIN_DIM - 1) && col_x >= CW'(WIN_DIM - 1)) begin
          tap_cnt_nxt = '0;
          state_nxt   = ST_MAC;
        end else if (!pix_op_r || int_cur) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_MAC: begin
        cmd.mac_step  = (32'(tap_cnt_r) < TAPS);
        cmd.mac_first = (tap_cnt_r == '0);
        ker_addr      = TAP_W'(TAPS - 1) - tap_cnt_r[TAP_W-1:0];
        tap_cnt_nxt   = tap_cnt_r + TC_W'(1);
        if (tap_cnt_r == TC_W'(TAPS + 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.out_last = last_r;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = done_r ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      row_r     <= '0;
      col_r     <= '0;
      pix_op_r  <= 1'b0;
      done_r    <= 1'b0;
      last_r    <= 1'b0;
      clr_cnt_r <= '0;
      tap_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      pix_op_r  <= pix_op_nxt;
      done_r    <= done_nxt;
      last_r    <= last_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      tap_cnt_r <= tap_cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pos_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (row_x < v_len && col_x < v_len))
    else $error("visit position off the grid");

  a_out_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a pending word");

  a_mac_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC && tap_cnt_r == TC_W'(TAPS + 1)) |=> (state_r == ST_OUT))
    else $error("MAC sequence did not end in output");
`endif

endmodule

// ===== sv/lbc2d_dp.sv =====
`timescale 1ns / 1ps
// Datapath: line store RAM, window registers, kernel RAM, serial MAC, output register.
// Depends on lbc2d_pkg and lbc2d_ram.
module lbc2d_dp #(
  parameter int WIN_DIM    = 3,
  parameter int LINE_DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  lbc2d_pkg::in_word_t                        in_word,
  input  lbc2d_pkg::dp_cmd_t                         cmd,
  input  logic [$clog2(LINE_DEPTH)-1:0]              line_addr,
  input  logic [$clog2(WIN_DIM*WIN_DIM)-1:0]         ker_addr,
  output lbc2d_pkg::dp_status_t                      status,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output lbc2d_pkg::out_word_t                       out_word
);
  import lbc2d_pkg::*;

  localparam int TAPS = WIN_DIM * WIN_DIM;
  localparam int LW   = (WIN_DIM - 1) * SAMPLE_WIDTH;
  localparam int PW   = 2 * SAMPLE_WIDTH;

  logic [SAMPLE_WIDTH-1:0] px_r, sample;
  logic [LW-1:0]           line_rdata, line_wdata, line_shift;
  logic [SAMPLE_WIDTH-1:0] win_r [TAPS];
  logic [SAMPLE_WIDTH-1:0] scan_r [TAPS];
  logic [SAMPLE_WIDTH-1:0] ker_rdata, ker_wdata;
  logic                    v1_r, v2_r, first1_r, first2_r;
  logic signed [PW-1:0]    prod_r, prod_q;
  logic [SAMPLE_WIDTH-1:0] acc_r;
  logic                    out_valid_r;
  out_word_t               out_word_r;

  assign sample = cmd.sample_zero ? '0 : px_r;

  always_comb begin
    for (int i = 0; i < WIN_DIM - 2; i++) begin
      line_shift[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] =
        line_rdata[(i+1)*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    end
    line_shift[(WIN_DIM-2)*SAMPLE_WIDTH +: SAMPLE_WIDTH] = sample;
  end

  assign line_wdata = cmd.clear ? '0 : line_shift;
  assign ker_wdata  = cmd.ker_zero ? '0 : in_word.coef_value;

  lbc2d_ram #(.WIDTH(LW), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (cmd.line_we),
    .waddr (line_addr),
    .wdata (line_wdata),
    .re    (cmd.line_re),
    .raddr (line_addr),
    .rdata (line_rdata)
  );

  lbc2d_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(TAPS)) u_ker_ram (
    .clk   (clk),
    .we    (cmd.ker_we),
    .waddr (ker_addr),
    .wdata (ker_wdata),
    .re    (cmd.mac_step),
    .raddr (ker_addr),
    .rdata (ker_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= in_word.pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAPS; k++) begin
        win_r[k] <= '0;
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < WIN_DIM; i++) begin
        for (int j = 0; j < WIN_DIM - 1; j++) begin
          win_r[i*WIN_DIM+j] <= win_r[i*WIN_DIM+j+1];
        end
      end
      for (int i = 0; i < WIN_DIM - 1; i++) begin
        win_r[i*WIN_DIM+WIN_DIM-1] <= line_rdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
      end
      win_r[TAPS-1] <= sample;
    end
  end

  // scan chain: window snapshot shifted out one tap per MAC step
  always_ff @(posedge clk) begin
    if (cmd.mac_first) begin
      for (int k = 0; k < TAPS; k++) begin
        scan_r[k] <= win_r[k];
      end
    end else if (v1_r) begin
      for (int k = 0; k < TAPS - 1; k++) begin
        scan_r[k] <= scan_r[k+1];
      end
      scan_r[TAPS-1] <= '0;
    end
  end

  assign prod_q = prod_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= $signed(scan_r[0]) * $signed(ker_rdata);
    end
    if (v2_r) begin
      acc_r <= (first2_r ? '0 : acc_r) + prod_q[SAMPLE_WIDTH-1:0];
    end
    first1_r <= cmd.mac_first;
    first2_r <= first1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_step;
      v2_r <= v1_r;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r.conv_value <= acc_r;
      out_word_r.frame_last <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  a_writeback_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.line_we && !cmd.clear) |-> ($past(cmd.line_re) && $past(line_addr) == line_addr))
    else $error("line write-back without matching read");

  a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!v1_r && !v2_r))
    else $error("result taken before MAC pipe drained");
`endif

endmodule

// ===== sim/line_buffer_conv2d_same_padding_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for line_buffer_conv2d_same_padding: random-stall stream
// driver, result monitor and a cycle-free convolution predictor.
// Depends on lbc2d_pkg and the block's top level.
module line_buffer_conv2d_same_padding_test;
  import lbc2d_pkg::*;

  localparam int K = WIN_DIM_DEF;
  localparam int PADW = (K - 1) / 2;
  localparam int MAX_SIDE = LINE_DEPTH_DEF - 2 * PADW;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  line_buffer_conv2d_same_padding dut (.*);

  always #1 clk = ~clk;

  in_word_t pend_words[$];
  out_word_t conv_expected[$];
  int errors = 0;
  int idle_cycles = 0;
  bit in_taken = 0;
  bit quiet = 0;
  bit long_hold_req = 0;
  int in_gap = 0;
  int out_hold = 0;

  // predictor state
  logic signed [SAMPLE_WIDTH-1:0] lines[K-1][LINE_DEPTH_DEF];
  logic signed [SAMPLE_WIDTH-1:0] win[K][K];
  logic signed [SAMPLE_WIDTH-1:0] taps[K*K];
  int grid_row, grid_col, side_reg;

  function automatic logic signed [SAMPLE_WIDTH-1:0] window_sum();
    longint acc;
    longint p;
    acc = 0;
    for (int i = 0; i < K; i++)
      for (int j = 0; j < K; j++) begin
        p = longint'(win[i][j]) * longint'(taps[(K-1-i)*K + (K-1-j)]);
        acc += p >>> FRAC_BITS;
      end
    return acc[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic bit at_interior(int s);
    return grid_row >= PADW && grid_row < s + PADW && grid_col >= PADW && grid_col < s + PADW;
  endfunction

  function automatic void visit_pos(int s, logic signed [SAMPLE_WIDTH-1:0] px);
    int v;
    out_word_t r;
    v = s + 2 * PADW;
    for (int i = 0; i < K; i++)
      for (int j = 0; j < K - 1; j++) win[i][j] = win[i][j+1];
    for (int i = 0; i < K - 1; i++) begin
      win[i][K-1] = lines[i][grid_col];
      lines[i][grid_col] = (i < K - 2) ? lines[i+1][grid_col] : px;
    end
    win[K-1][K-1] = px;
    if (grid_row >= K - 1 && grid_col >= K - 1) begin
      r.conv_value = window_sum();
      r.frame_last = (grid_row == v - 1 && grid_col == v - 1);
      conv_expected.push_back(r);
    end
    grid_col++;
    if (grid_col >= v) begin
      grid_col = 0;
      grid_row++;
      if (grid_row >= v) grid_row = 0;
    end
  endfunction

  function automatic void predict_word(in_word_t w);
    int s, v;
    s = side_reg;
    if (s < 1) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    v = s + 2 * PADW;
    if (w.opcode == OP_COEF) begin
      if (w.coef_index < K * K) taps[w.coef_index] = w.coef_value;
      return;
    end
    if (w.opcode != OP_PIXEL && w.opcode != OP_DRAIN) return;
    if (grid_row >= v || grid_col >= v) begin
      grid_row = 0;
      grid_col = 0;
    end
    if (w.opcode == OP_DRAIN) begin
      if (!at_interior(s)) visit_pos(s, '0);
      return;
    end
    if (grid_row > s + PADW - 1 || (grid_row == s + PADW - 1 && grid_col > s + PADW - 1))
      return;
    while (!at_interior(s)) visit_pos(s, '0);
    visit_pos(s, w.pixel_value);
  endfunction

  function automatic in_word_t mk(logic [OPCODE_W-1:0] op, logic [15:0] px,
                                  logic [COEF_IDX_W-1:0] idx, logic [15:0] cv);
    in_word_t w;
    w.opcode = op;
    w.pixel_value = px;
    w.coef_index = idx;
    w.coef_value = cv;
    return w;
  endfunction

  // one frame of random pixels, with optional noise, then the trailing drains
  task automatic queue_frame(int s, bit noisy);
    for (int i = 0; i < s * s; i++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        pend_words.push_back(mk(OPCODE_W'($urandom_range(0, 3)), 16'($urandom),
                                COEF_IDX_W'($urandom), 16'($urandom)));
      pend_words.push_back(mk(OP_PIXEL, 16'($urandom), COEF_IDX_W'($urandom),
                              16'($urandom)));
    end
    for (int i = 0; i < PADW * (s + 2 * PADW + 1); i++)
      pend_words.push_back(mk(OP_DRAIN, 16'($urandom), COEF_IDX_W'($urandom),
                              16'($urandom)));
  endtask

  task automatic wait_idle();
    wait (pend_words.size() == 0 && !in_valid && conv_expected.size() == 0);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_side(int value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    side_reg = value & 10'h3FF;
  endtask

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pend_words.size() > 0) begin
        in_word <= pend_words.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req <= 1'b0;
      out_hold <= 300;
      out_stall <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_hold <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    in_taken = 0;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        predict_word(in_word);
        in_taken = 1;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (conv_expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %h", out_word);
        end else if (out_word !== conv_expected[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                     conv_expected[0].conv_value, conv_expected[0].frame_last,
                     out_word.conv_value, out_word.frame_last);
          void'(conv_expected.pop_front());
        end else begin
          void'(conv_expected.pop_front());
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int s;
    for (int i = 0; i < K - 1; i++)
      for (int j = 0; j < LINE_DEPTH_DEF; j++) lines[i][j] = '0;
    for (int i = 0; i < K; i++)
      for (int j = 0; j < K; j++) win[i][j] = '0;
    for (int i = 0; i < K * K; i++) taps[i] = '0;
    grid_row = 0;
    grid_col = 0;
    side_reg = SIDE_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    write_side(3);
    pend_words.push_back(mk(OP_COEF, 0, 0, 16'h7FFF));
    pend_words.push_back(mk(OP_COEF, 0, 1, 16'h8000));
    pend_words.push_back(mk(OP_COEF, 0, 2, 16'hFFFF));
    pend_words.push_back(mk(OP_COEF, 0, 4, 16'h0100));
    pend_words.push_back(mk(OP_COEF, 0, 8, 16'h0001));
    pend_words.push_back(mk(OP_COEF, 0, 49, 16'h1234));
    pend_words.push_back(mk(OP_COEF, 0, 63, 16'hFFFF));
    pend_words.push_back(mk(OP_UNUSED, 16'hFFFF, 63, 16'hFFFF));
    pend_words.push_back(mk(OP_PIXEL, 16'h7FFF, 0, 0));
    pend_words.push_back(mk(OP_DRAIN, 0, 0, 0));
    pend_words.push_back(mk(OP_PIXEL, 16'h8000, 0, 0));
    pend_words.push_back(mk(OP_PIXEL, 16'hFFFF, 0, 0));
    pend_words.push_back(mk(OP_PIXEL, 16'h0000, 0, 0));
    pend_words.push_back(mk(OP_PIXEL, 16'h7FFF, 0, 0));
    pend_words.push_back(mk(OP_PIXEL, 16'h8000, 0, 0));
    pend_words.push_back(mk(OP_PIXEL, 16'h0001, 0, 0));
    pend_words.push_back(mk(OP_PIXEL, 16'h7FFF, 0, 0));
    pend_words.push_back(mk(OP_PIXEL, 16'h8000, 0, 0));
    pend_words.push_back(mk(OP_PIXEL, 16'h5555, 0, 0));
    for (int i = 0; i < 6; i++) pend_words.push_back(mk(OP_DRAIN, 0, 0, 0));
    wait_idle();

    // random frames
    for (int f = 0; f < 4; f++) begin
      for (int i = 0; i < 3; i++)
        pend_words.push_back(mk(OP_COEF, 16'($urandom), COEF_IDX_W'($urandom_range(0, 8)),
                                16'($urandom)));
      s = $urandom_range(1, 5);
      if (f % 2 == 0) begin
        wait_idle();
        write_side(s);
      end else s = side_reg;
      if (s < 1) s = 1;
      queue_frame(s, 1);
      if (f == 0) long_hold_req = 1;
    end

    // side extremes: zero, then beyond the largest side the line depth allows
    wait_idle();
    write_side(0);
    queue_frame(1, 0);
    wait_idle();
    write_side(10'h3FF);
    pend_words.push_back(mk(OP_PIXEL, 16'($urandom), 0, 0));
    pend_words.push_back(mk(OP_PIXEL, 16'($urandom), 0, 0));
    wait_idle();
    write_side(4);
    quiet = 1;
    queue_frame(4, 0);

    wait (pend_words.size() == 0 && !in_valid && conv_expected.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && conv_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
